### rtl/core/bsmt_pkg.sv
package bsmt_pkg;

    // Set capacity and derived widths
    localparam int SET_CAPACITY = 128;
    localparam int CNT_W        = $clog2(SET_CAPACITY + 1);
    localparam int DATA_W       = 32;

    // Hit reduction: cells are ORed in groups, one register per group
    localparam int GRP_SIZE = 16;
    localparam int GRP_NUM  = (SET_CAPACITY + GRP_SIZE - 1) / GRP_SIZE;
    localparam int HIT_W    = GRP_NUM * GRP_SIZE;

    // Operation codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;

    // Per-cycle controls broadcast to every cell
    typedef struct packed {
        logic cmp_en;      // register the compare result
        logic shift_up;    // take lower neighbor (cell 0 takes the key)
        logic shift_down;  // take upper neighbor
        logic fill_head;   // matching cell takes the head cell's value
    } cell_ctl_t;

endpackage

### rtl/core/bsmt_cell.sv
module bsmt_cell (
    input  logic                       aclk,
    input  bsmt_pkg::cell_ctl_t        ctl,
    input  logic                       entry_valid,
    input  logic [bsmt_pkg::DATA_W-1:0] key,
    input  logic [bsmt_pkg::DATA_W-1:0] dn_data,
    input  logic [bsmt_pkg::DATA_W-1:0] up_data,
    input  logic [bsmt_pkg::DATA_W-1:0] head_data,
    output logic [bsmt_pkg::DATA_W-1:0] data,
    output logic                       hit
);

    logic [bsmt_pkg::DATA_W-1:0] data_reg;
    logic                        hit_reg;

    // Stored entry: shifts along the chain or takes the head value on a remove
    always_ff @(posedge aclk) begin
        if (ctl.shift_up) begin
            data_reg <= dn_data;
        end else if (ctl.shift_down) begin
            data_reg <= up_data;
        end else if (ctl.fill_head && hit_reg) begin
            data_reg <= head_data;
        end
    end

    // Registered compare against the current request key
    always_ff @(posedge aclk) begin
        if (ctl.cmp_en) begin
            hit_reg <= entry_valid && (data_reg == key);
        end
    end

    assign data = data_reg;
    assign hit  = hit_reg;

endmodule

### rtl/core/bsmt_hit_tree.sv
module bsmt_hit_tree (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [bsmt_pkg::HIT_W-1:0]  hits,
    output logic                        any_hit
);

    logic [bsmt_pkg::GRP_NUM-1:0] grp_reg;

    // First level: one registered OR per group of cells
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int g = 0; g < bsmt_pkg::GRP_NUM; g++) begin
                grp_reg[g] <= |hits[g*bsmt_pkg::GRP_SIZE +: bsmt_pkg::GRP_SIZE];
            end
        end
    end

    // Final level over the group results
    assign any_hit = |grp_reg;

endmodule

### rtl/core/bounded_set_membership_table_top.sv
// Requests are handled one at a time: a new one is accepted only once the
// previous one is done. A remove of a present value adds a step, the
// chain-wide shift that drops the head cell. Combine waits for a free output.
// Each request passes compare (in the cells), group OR, and combine/update.
// Reset (aresetn low, synchronous) empties the set and clears the handshake;
// cell contents are not cleared, entries at or above the count are ignored.
module bounded_set_membership_table_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic [1:0]  s_tuser,   // [1:0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [0] was_present, [8:1] element_total,
                                   // [9] insert_rejected, [15:10] zero
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CMP   = 3'd1;
    localparam logic [2:0] ST_RED   = 3'd2;
    localparam logic [2:0] ST_RES   = 3'd3;
    localparam logic [2:0] ST_SHIFT = 3'd4;

    localparam int CAP   = bsmt_pkg::SET_CAPACITY;
    localparam int CNT_W = bsmt_pkg::CNT_W;

    logic [2:0]                    state_reg, state_next;
    logic [1:0]                    op_reg;
    logic [bsmt_pkg::DATA_W-1:0]   key_reg;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic                          m_valid_reg;
    logic [15:0]                   m_data_reg;

    logic [bsmt_pkg::DATA_W-1:0]   cell_data [CAP];
    logic [CAP-1:0]                hit_vec;
    logic [bsmt_pkg::HIT_W-1:0]    hit_pad;
    logic                          present;
    logic                          out_free;
    logic                          full;
    logic                          do_insert;
    logic                          do_remove;
    logic                          rejected;
    logic                          s_accept;
    bsmt_pkg::cell_ctl_t           ctl;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign full     = (count_reg == CNT_W'(CAP));

    // Update decisions, taken in the combine state once the output is free
    assign do_insert = (state_reg == ST_RES) && out_free && (op_reg == bsmt_pkg::OP_INSERT)
                       && !present && !full;
    assign do_remove = (state_reg == ST_RES) && out_free && (op_reg == bsmt_pkg::OP_REMOVE)
                       && present;
    assign rejected  = (op_reg == bsmt_pkg::OP_INSERT) && !present && full;

    assign ctl.cmp_en     = (state_reg == ST_CMP);
    assign ctl.shift_up   = do_insert;
    assign ctl.fill_head  = do_remove;
    assign ctl.shift_down = (state_reg == ST_SHIFT);

    // Chain of entry cells; each insert enters at cell 0 and shifts the others up
    for (genvar i = 0; i < CAP; i++) begin : g_cell
        logic [bsmt_pkg::DATA_W-1:0] dn_data;
        logic [bsmt_pkg::DATA_W-1:0] up_data;
        logic                        entry_valid;

        if (i == 0) begin : g_first
            assign dn_data = key_reg;
        end else begin : g_mid
            assign dn_data = cell_data[i-1];
        end
        if (i == CAP - 1) begin : g_last
            assign up_data = cell_data[i];
        end else begin : g_inner
            assign up_data = cell_data[i+1];
        end
        assign entry_valid = (CNT_W'(i) < count_reg);

        bsmt_cell u_cell (
            .aclk        (aclk),
            .ctl         (ctl),
            .entry_valid (entry_valid),
            .key         (key_reg),
            .dn_data     (dn_data),
            .up_data     (up_data),
            .head_data   (cell_data[0]),
            .data        (cell_data[i]),
            .hit         (hit_vec[i])
        );
    end

    assign hit_pad = bsmt_pkg::HIT_W'(hit_vec);

    bsmt_hit_tree u_hit_tree (
        .aclk    (aclk),
        .en      (state_reg == ST_RED),
        .hits    (hit_pad),
        .any_hit (present)
    );

    // Sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_accept) state_next = ST_CMP;
            ST_CMP:   state_next = ST_RED;
            ST_RED:   state_next = ST_RES;
            ST_RES: begin
                if (out_free) begin
                    state_next = do_remove ? ST_SHIFT : ST_IDLE;
                end
            end
            ST_SHIFT: state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Element count after the request
    always_comb begin
        count_next = count_reg;
        if (do_insert) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_remove) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if ((state_reg == ST_RES) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Request capture and result payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            op_reg  <= s_tuser;
            key_reg <= s_tdata;
        end
        if ((state_reg == ST_RES) && out_free) begin
            m_data_reg <= {6'd0, rejected, 8'(count_next), present};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

### tb/set_table_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the set table, keeps its own copy of the set,
// predicts the result of every accepted request and compares field by field.
module set_table_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic [1:0]  s_tuser,   // [1:0] op
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // [0] was_present, [8:1] element_total,
                                   // [9] insert_rejected, [15:10] zero
    output int unsigned fail_count,
    output int unsigned pending_count,
    output int unsigned checked_count,
    output int unsigned reject_count,
    output int unsigned peak_total
);

    // Result layout, MSB first so it maps straight onto m_tdata
    typedef struct packed {
        logic [5:0] pad;
        logic       insert_rejected;
        logic [7:0] element_total;
        logic       was_present;
    } set_result_t;

    // Model of the table: first member_total entries are valid
    logic [31:0] member_vals [bsmt_pkg::SET_CAPACITY];
    int unsigned member_total;
    set_result_t expected_results[$];

    initial begin
        fail_count    = 0;
        pending_count = 0;
        checked_count = 0;
        reject_count  = 0;
        peak_total    = 0;
        member_total  = 0;
    end

    // Apply one request to the model, return the result it should give
    function automatic set_result_t apply_request(logic [1:0] op, logic [31:0] value);
        set_result_t res;
        int          hit_idx;
        res     = '0;
        hit_idx = -1;
        for (int i = 0; i < int'(member_total); i++) begin
            if (hit_idx < 0 && member_vals[i] == value)
                hit_idx = i;
        end
        res.was_present = (hit_idx >= 0);
        if (op == bsmt_pkg::OP_INSERT) begin
            if (hit_idx < 0) begin
                if (member_total < bsmt_pkg::SET_CAPACITY) begin
                    member_vals[member_total] = value;
                    member_total++;
                end else begin
                    res.insert_rejected = 1'b1;
                end
            end
        end else if (op == bsmt_pkg::OP_REMOVE && hit_idx >= 0) begin
            // last valid entry fills the freed slot
            member_vals[hit_idx] = member_vals[member_total - 1];
            member_total--;
        end
        // anything else is a plain lookup
        res.element_total = 8'(member_total);
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH at %0t ns: %s got %0h expected %0h", $time, what, got, want);
        fail_count++;
    endtask

    // Compare results first, then predict for the request accepted at this edge
    always @(posedge aclk) begin : watch
        set_result_t got;
        set_result_t want;
        if (!aresetn) begin
            member_total = 0;
            expected_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = set_result_t'(m_tdata);
                if (expected_results.size() == 0) begin
                    report_mismatch("result with no request outstanding", 32'(m_tdata), '0);
                end else begin
                    want = expected_results.pop_front();
                    checked_count++;
                    if (got.was_present !== want.was_present)
                        report_mismatch("was_present", 32'(got.was_present),
                                        32'(want.was_present));
                    if (got.element_total !== want.element_total)
                        report_mismatch("element_total", 32'(got.element_total),
                                        32'(want.element_total));
                    if (got.insert_rejected !== want.insert_rejected)
                        report_mismatch("insert_rejected", 32'(got.insert_rejected),
                                        32'(want.insert_rejected));
                    if (got.pad !== want.pad)
                        report_mismatch("padding bits", 32'(got.pad), 32'(want.pad));
                end
            end
            if (s_tvalid && s_tready) begin
                want = apply_request(s_tuser, s_tdata);
                expected_results.push_back(want);
                if (want.insert_rejected)
                    reject_count++;
                if (member_total > peak_total)
                    peak_total = member_total;
            end
        end
        pending_count = expected_results.size();
    end

endmodule

### tb/bounded_set_membership_table_top_tb.sv
`timescale 1ns / 100ps

module bounded_set_membership_table_top_tb;

    // Op codes: insert and remove from the package, the rest local
    localparam logic [1:0] OP_INSERT = bsmt_pkg::OP_INSERT;
    localparam logic [1:0] OP_REMOVE = bsmt_pkg::OP_REMOVE;
    localparam logic [1:0] OP_QUERY  = 2'd2;
    localparam logic [1:0] OP_SPARE  = 2'd3;

    localparam int POOL_SIZE  = 200;
    localparam int STALL_LEN  = 300;
    localparam int DRAIN_WAIT = 20;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // [31:0] value
    logic [1:0]  s_tuser  = '0;   // [1:0] op
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // [0] was_present, [8:1] element_total,
                                  // [9] insert_rejected, [15:10] zero

    int unsigned fail_count;
    int unsigned pending_count;
    int unsigned checked_count;
    int unsigned reject_count;
    int unsigned peak_total;

    // Idle knobs for the two driving processes, plus the sent request count
    int unsigned send_gap_pct = 0;
    int unsigned recv_gap_pct = 0;
    bit          stall_ask    = 1'b0;
    int unsigned sent_count   = 0;

    logic [31:0] value_pool [POOL_SIZE];

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    bounded_set_membership_table_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    set_table_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .checked_count (checked_count),
        .reject_count  (reject_count),
        .peak_total    (peak_total)
    );

    // Offer one request, optionally after an idle burst; return once accepted
    task automatic send_request(logic [1:0] op, logic [31:0] value);
        if ($urandom_range(0, 99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent_count++;
    endtask

    // Wait on the falling edge so the checker's count has settled
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending_count != 0) @(negedge aclk);
        @(posedge aclk);
    endtask

    // Random phase: op mix in percent, remainder are lookups (a few unused ops)
    task automatic run_phase(int unsigned count, int unsigned ins_pct, int unsigned rem_pct);
        int unsigned pick;
        logic [1:0]  op;
        logic [31:0] value;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < ins_pct)
                op = OP_INSERT;
            else if (pick < ins_pct + rem_pct)
                op = OP_REMOVE;
            else if (pick < 97)
                op = OP_QUERY;
            else
                op = OP_SPARE;
            if ($urandom_range(0, 99) < 85)
                value = value_pool[$urandom_range(0, POOL_SIZE - 1)];
            else
                value = $urandom;
            send_request(op, value);
        end
    endtask

    // Receiver: random ready bursts, one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (stall_ask) begin
                stall_ask = 1'b0;
                m_tready <= 1'b0;
                repeat (STALL_LEN) @(posedge aclk);
                m_tready <= 1'b1;
            end else if (aresetn && $urandom_range(0, 99) < recv_gap_pct) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= aresetn;
            end
        end
    end

    // Stimulus and verdict
    initial begin
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7FFF_FFFF;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hFFFF_FFFF;
        for (int i = 4; i < POOL_SIZE; i++)
            value_pool[i] = $urandom;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extremes, duplicates, absent removes, swap-with-last, unused op
        send_gap_pct = 20;
        recv_gap_pct = 20;
        send_request(OP_INSERT, 32'h8000_0000);
        send_request(OP_INSERT, 32'h7FFF_FFFF);
        send_request(OP_INSERT, 32'h0000_0000);
        send_request(OP_INSERT, 32'hFFFF_FFFF);
        send_request(OP_INSERT, 32'h0000_0000);
        send_request(OP_QUERY,  32'h7FFF_FFFF);
        send_request(OP_QUERY,  32'h0000_0001);
        send_request(OP_SPARE,  32'hFFFF_FFFF);
        send_request(OP_SPARE,  32'h1234_5678);
        send_request(OP_REMOVE, 32'h1234_5678);
        send_request(OP_REMOVE, 32'h8000_0000);
        send_request(OP_QUERY,  32'hFFFF_FFFF);
        send_request(OP_QUERY,  32'h8000_0000);
        send_request(OP_REMOVE, 32'hFFFF_FFFF);
        send_request(OP_REMOVE, 32'hFFFF_FFFF);
        send_request(OP_INSERT, 32'h8000_0000);
        send_request(OP_REMOVE, 32'h0000_0000);
        send_request(OP_REMOVE, 32'h7FFF_FFFF);
        send_request(OP_REMOVE, 32'h8000_0000);
        send_request(OP_REMOVE, 32'h0000_0001);
        send_request(OP_QUERY,  32'h0000_0000);

        // Fill past capacity so absent inserts get rejected
        send_gap_pct = 10;
        recv_gap_pct = 10;
        run_phase(300, 85, 5);

        // Long receiver hold-off while requests keep coming, then drain the set
        stall_ask    = 1'b1;
        send_gap_pct = 5;
        run_phase(250, 20, 60);

        // Sender pauses until every result is back
        wait_drained();

        send_gap_pct = 25;
        recv_gap_pct = 25;
        run_phase(300, 50, 35);

        // Final stretch at full rate on both sides
        send_gap_pct = 0;
        recv_gap_pct = 0;
        run_phase(250, 45, 40);

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("Run covered %0d requests and %0d checked results: inserts, removes,",
                 sent_count, checked_count);
        $display("lookups and unused ops; peak fill %0d of %0d, %0d full-set rejects.",
                 peak_total, bsmt_pkg::SET_CAPACITY, reject_count);
        if (fail_count == 0 && pending_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #3_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
